>>> hw/rtl/trimmed_mean_window_filter_defines.svh
// Assertion macros for the trimmed-mean window filter.
// Included by modules that check their own control logic; needs clock and reset in scope.
`ifndef TRIMMED_MEAN_WINDOW_FILTER_DEFINES_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define TMWF_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TMWF_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/tmwf_pkg.sv
// Shared constants and types for the trimmed-mean window filter.
// No dependencies.
package tmwf_pkg;

   localparam int DEFAULT_WINDOW_SIZE = 16;
   localparam int SAMPLE_W            = 16;
   localparam int SMOOTH_W            = 20;
   localparam int FRAC_W              = 4;
   localparam int REQ_TDATA_W         = 16;
   localparam int RSP_TDATA_W         = 24;

   // trim points, percent of the window
   localparam int TRIM_LO_PCT = 15;
   localparam int TRIM_HI_PCT = 85;
   localparam int PCT_DEN     = 100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_OLD,
      ST_SCAN,
      ST_MERGE,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/trimmed_mean_window_filter.sv
// Trimmed-mean window filter: top level, single module.
// Depends on tmwf_pkg and trimmed_mean_window_filter_defines.svh.

// Each request carries one signed 16-bit sample. The sample goes into a ring of
// WINDOW_SIZE entries (the ring index advances before the write, so the first
// sample after reset lands in entry 1), and the block returns one response: the
// mean of the window with the lowest max(N*15/100,1) and the highest entries from
// min(N*85/100+1,N-1) upward dropped, as signed fixed point with 4 fraction bits,
// rounded toward minus infinity. Entries never written count as zero. Two
// one-read, one-write memories hold the state: the sample ring, and a copy of the
// window kept in ascending order. Per request the sorted copy is scanned once to
// find the departing sample and the insert slot, then rewritten in a second pass
// that also sums the kept entries; one multiply by the constant reciprocal of the
// fixed kept count then gives the mean. A new request is taken only after the
// previous one has gone through both memory passes, the divide and the load of
// its response. A finished response waits in an output register, and the next
// request is taken while it does. No clearing pass is needed after reset.

`include "trimmed_mean_window_filter_defines.svh"

module trimmed_mean_window_filter #(
   parameter int WINDOW_SIZE = tmwf_pkg::DEFAULT_WINDOW_SIZE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tmwf_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [15:0] sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tmwf_pkg::RSP_TDATA_W-1:0]    rsp_tdata    // [19:0] smoothed, rest zero
);

   localparam int SW       = tmwf_pkg::SAMPLE_W;
   localparam int IW       = $clog2(WINDOW_SIZE);
   localparam int LO_RAW   = WINDOW_SIZE * tmwf_pkg::TRIM_LO_PCT / tmwf_pkg::PCT_DEN;
   localparam int TRIM_LO  = (LO_RAW < 1) ? 1 : LO_RAW;
   localparam int HI_RAW   = WINDOW_SIZE * tmwf_pkg::TRIM_HI_PCT / tmwf_pkg::PCT_DEN + 1;
   localparam int TRIM_HI  = (HI_RAW > WINDOW_SIZE - 1) ? WINDOW_SIZE - 1 : HI_RAW;
   localparam int KEEP     = TRIM_HI - TRIM_LO;
   localparam int SUMW     = SW + IW;
   localparam int NUMW     = SUMW + tmwf_pkg::FRAC_W;
   localparam int CNT_LAST = WINDOW_SIZE + 1;
   localparam int CNTW     = $clog2(CNT_LAST + 1);
   // reciprocal of the kept count, exact floor for any NUMW-bit dividend
   localparam int     RCP_SH = NUMW + $clog2(KEEP);
   localparam longint RCP    = ((longint'(1) << RCP_SH) + longint'(KEEP) - 1) / KEEP;
   localparam int     PRODW  = RCP_SH + NUMW;

   // control
   tmwf_pkg::state_type state_ff, state_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [IW-1:0]       idx_ff, idx_in;        // ring write index
   logic                primed_ff, primed_in;  // sorted copy written at least once
   logic [WINDOW_SIZE-1:0] win_vld_ff;
   logic                found_ff, found_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   // payload
   logic signed [SW-1:0]   x_ff, x_in;         // new sample
   logic signed [SW-1:0]   r_ff, r_in;         // departing sample
   logic [IW-1:0]          pos_p_ff, pos_p_in; // slot of departing sample
   logic [IW-1:0]          pos_q_ff, pos_q_in; // insert slot after removal
   logic signed [SW-1:0]   sh1_ff, sh1_in, sh2_ff, sh2_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic                   neg_ff, neg_in;
   logic [NUMW-1:0]        dq_ff, dq_in;       // dividend magnitude, then quotient
   logic [tmwf_pkg::SMOOTH_W-1:0] rsp_data_ff, rsp_data_in;

   // memories
   logic signed [SW-1:0] win_mem [WINDOW_SIZE];
   logic signed [SW-1:0] srt_mem [WINDOW_SIZE];
   logic signed [SW-1:0] win_q_ff;
   logic signed [SW-1:0] srt_q_ff;

   logic                 accept;
   logic [IW-1:0]        idx_next;
   logic                 win_wr_en;
   logic                 srt_rd_en;
   logic [IW-1:0]        srt_rd_addr;
   logic                 srt_wr_en;
   logic [IW-1:0]        k_idx;
   logic [IW-1:0]        j_idx;
   logic signed [SW-1:0] s_val;
   logic signed [SW-1:0] r_val;
   logic signed [SW-1:0] new_val;
   logic                 keep_k;
   logic [NUMW-1:0]      num_w;
   logic [PRODW-1:0]     prod;
   logic [NUMW-1:0]      res_full;
   logic                 rsp_load;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = (state_ff == tmwf_pkg::ST_IDLE);
   assign rsp_tvalid  = rsp_tvalid_ff;
   assign rsp_tdata   = {{(tmwf_pkg::RSP_TDATA_W - tmwf_pkg::SMOOTH_W){1'b0}}, rsp_data_ff};

   assign idx_next    = (idx_ff == IW'(WINDOW_SIZE - 1)) ? '0 : idx_ff + IW'(1);
   assign win_wr_en   = (state_ff == tmwf_pkg::ST_READ_OLD);
   assign srt_rd_en   = ((state_ff == tmwf_pkg::ST_SCAN) || (state_ff == tmwf_pkg::ST_MERGE))
                        && (cnt_ff < CNTW'(WINDOW_SIZE));
   assign srt_rd_addr = cnt_ff[IW-1:0];
   assign srt_wr_en   = (state_ff == tmwf_pkg::ST_MERGE) && (cnt_ff >= CNTW'(2));
   assign j_idx       = cnt_ff[IW-1:0] - IW'(1);
   assign k_idx       = cnt_ff[IW-1:0] - IW'(2);

   // sorted copy reads as zeros until its first full rewrite
   assign s_val = primed_ff ? srt_q_ff : '0;
   assign r_val = win_vld_ff[idx_ff] ? win_q_ff : '0;

   // rewrite of slot k: drop the departing sample at p, insert the new one at q
   always_comb begin
      if (k_idx < pos_q_ff) begin
         new_val = (k_idx < pos_p_ff) ? sh1_ff : s_val;
      end else if (k_idx == pos_q_ff) begin
         new_val = x_ff;
      end else begin
         new_val = (k_idx <= pos_p_ff) ? sh2_ff : sh1_ff;
      end
   end

   assign keep_k = (k_idx >= IW'(TRIM_LO)) && (k_idx < IW'(TRIM_HI));

   // divide by the kept count: multiply by its reciprocal, keep the top bits
   assign num_w = {sum_ff, {tmwf_pkg::FRAC_W{1'b0}}};
   assign prod  = PRODW'(dq_ff) * PRODW'(RCP);

   // negative magnitude carried a KEEP-1 bias, so negating rounds to the floor
   assign res_full = !neg_ff ? dq_ff : (~dq_ff + NUMW'(1));
   assign rsp_load = (state_ff == tmwf_pkg::ST_DONE) && (!rsp_tvalid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmwf_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = tmwf_pkg::ST_READ_OLD;
         end
         tmwf_pkg::ST_READ_OLD: begin
            state_in = tmwf_pkg::ST_SCAN;
         end
         tmwf_pkg::ST_SCAN: begin
            if (cnt_ff == CNTW'(WINDOW_SIZE)) state_in = tmwf_pkg::ST_MERGE;
         end
         tmwf_pkg::ST_MERGE: begin
            if (cnt_ff == CNTW'(WINDOW_SIZE + 1)) state_in = tmwf_pkg::ST_DIV;
         end
         tmwf_pkg::ST_DIV: begin
            state_in = tmwf_pkg::ST_DONE;
         end
         tmwf_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = tmwf_pkg::ST_IDLE;
         end
         default: begin
            state_in = tmwf_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      primed_in     = primed_ff;
      found_in      = found_ff;
      x_in          = x_ff;
      r_in          = r_ff;
      pos_p_in      = pos_p_ff;
      pos_q_in      = pos_q_ff;
      sh1_in        = sh1_ff;
      sh2_in        = sh2_ff;
      sum_in        = sum_ff;
      neg_in        = neg_ff;
      dq_in         = dq_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         tmwf_pkg::ST_IDLE: begin
            if (accept) begin
               x_in   = signed'(req_tdata[SW-1:0]);
               idx_in = idx_next;
            end
         end
         tmwf_pkg::ST_READ_OLD: begin
            r_in     = r_val;
            cnt_in   = '0;
            found_in = 1'b0;
            pos_p_in = IW'(WINDOW_SIZE - 1);
            pos_q_in = '0;
         end
         tmwf_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff != '0) begin
               if (!found_ff && (s_val == r_ff)) begin
                  found_in = 1'b1;
                  pos_p_in = j_idx;
               end else if (s_val < x_ff) begin
                  pos_q_in = pos_q_ff + IW'(1);
               end
            end
            if (cnt_ff == CNTW'(WINDOW_SIZE)) begin
               cnt_in = '0;
               sum_in = '0;
            end
         end
         tmwf_pkg::ST_MERGE: begin
            cnt_in = cnt_ff + CNTW'(1);
            sh1_in = s_val;
            sh2_in = sh1_ff;
            if (srt_wr_en && keep_k) begin
               sum_in = sum_ff + SUMW'(new_val);
            end
            if (cnt_ff == CNTW'(WINDOW_SIZE + 1)) begin
               // top slot is never kept, so the sum is complete here
               cnt_in    = '0;
               primed_in = 1'b1;
               neg_in    = sum_ff[SUMW-1];
               // negative: magnitude plus KEEP-1, so the quotient rounds up
               dq_in     = sum_ff[SUMW-1] ? (~num_w + NUMW'(KEEP)) : num_w;
            end
         end
         tmwf_pkg::ST_DIV: begin
            dq_in = prod[RCP_SH +: NUMW];
         end
         tmwf_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_data_in   = res_full[tmwf_pkg::SMOOTH_W-1:0];
               rsp_tvalid_in = 1'b1;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tmwf_pkg::ST_IDLE;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         primed_ff     <= 1'b0;
         found_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         win_vld_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         primed_ff     <= primed_in;
         found_ff      <= found_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (win_wr_en) win_vld_ff[idx_ff] <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      r_ff        <= r_in;
      pos_p_ff    <= pos_p_in;
      pos_q_ff    <= pos_q_in;
      sh1_ff      <= sh1_in;
      sh2_ff      <= sh2_in;
      sum_ff      <= sum_in;
      neg_ff      <= neg_in;
      dq_ff       <= dq_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (win_wr_en) win_mem[idx_ff] <= x_ff;
      if (accept) win_q_ff <= win_mem[idx_next];
   end

   // sorted copy; pass writes trail reads by two slots
   always_ff @(posedge clock) begin
      if (srt_wr_en) srt_mem[k_idx] <= new_val;
      if (srt_rd_en) srt_q_ff <= srt_mem[srt_rd_addr];
   end

   `TMWF_ASSERT_NEXT(a_accept_reads_old, accept, state_ff == tmwf_pkg::ST_READ_OLD,
      "accepted request did not start the ring read")
   `TMWF_ASSERT_NEXT(a_old_sample_found,
      (state_ff == tmwf_pkg::ST_SCAN) && (cnt_ff == CNTW'(WINDOW_SIZE)), found_ff,
      "departing sample missing from sorted copy")
   `TMWF_ASSERT_NEXT(a_div_single, state_ff == tmwf_pkg::ST_DIV,
      state_ff == tmwf_pkg::ST_DONE, "divide step took more than one cycle")
   `TMWF_ASSERT_NEXT(a_done_waits,
      (state_ff == tmwf_pkg::ST_DONE) && rsp_tvalid_ff && !rsp_tready,
      (state_ff == tmwf_pkg::ST_DONE) && rsp_tvalid_ff,
      "pending response overwritten")

endmodule
